### sv/assert_macros.svh
// Assertion macros shared by the column sequencer modules.
// Needs nothing else; taken in by `include where checks are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while in reset.
`define ACSQ_ASSERT_IMP(name, clk_i, rst_ni, ante, cons) \
    name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
        else $error("acsq check failed");

// Next-cycle implication, held off while in reset.
`define ACSQ_ASSERT_NXT(name, clk_i, rst_ni, ante, cons) \
    name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
        else $error("acsq check failed");

`endif

### sv/acsq_pkg.sv
// Types and constants for the adsorption column sequencer.
// No dependencies; imported by every module of the block.
package acsq_pkg;

    localparam int TIME_W  = 24;
    localparam int TEMP_W  = 13;
    localparam int PRES_W  = 14;
    localparam int CYC_W   = 16;
    localparam int IDX_W   = 2;
    localparam int PHASE_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int QUEUE_DEPTH = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COOL_TIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_COOL_TIME = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_HEAT_TIME = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HEAT_TIME = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DESORB_TEMP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ABSORB_TEMP   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VENT_PRESSURE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FEED_PRESSURE = 3'd7;

    // Phase codes as seen on the result
    localparam logic [PHASE_W-1:0] CODE_INIT   = 3'd0;
    localparam logic [PHASE_W-1:0] CODE_ABSORB = 3'd1;
    localparam logic [PHASE_W-1:0] CODE_PUMP   = 3'd2;
    localparam logic [PHASE_W-1:0] CODE_SEAL   = 3'd3;
    localparam logic [PHASE_W-1:0] CODE_DESORB = 3'd4;
    localparam logic [PHASE_W-1:0] CODE_COOL   = 3'd5;

    typedef enum logic [5:0] {
        ST_INIT   = 6'b000001,
        ST_ABSORB = 6'b000010,
        ST_PUMP   = 6'b000100,
        ST_SEAL   = 6'b001000,
        ST_DESORB = 6'b010000,
        ST_COOL   = 6'b100000
    } phase_t;

    typedef struct packed {
        logic        [TIME_W-1:0] min_cool_time;
        logic        [TIME_W-1:0] max_cool_time;
        logic        [TIME_W-1:0] min_heat_time;
        logic        [TIME_W-1:0] max_heat_time;
        logic signed [TEMP_W-1:0] desorb_temp;
        logic signed [TEMP_W-1:0] absorb_temp;
        logic        [PRES_W-1:0] vent_pressure;
        logic        [PRES_W-1:0] feed_pressure;
    } cfg_t;

    // Classified request as it sits in the queue
    typedef struct packed {
        logic        [IDX_W-1:0]  column_index;
        logic                     in_range;
        logic signed [TEMP_W-1:0] temperature;
        logic        [PRES_W-1:0] pressure;
        logic                     cool_min_ok;
        logic                     cool_max_hit;
        logic                     heat_min_ok;
        logic                     heat_max_hit;
    } item_t;

    typedef struct packed {
        phase_t                   phase;
        logic signed [TEMP_W-1:0] temp;
        logic        [PRES_W-1:0] inlet;
        logic        [PRES_W-1:0] outlet;
        logic        [CYC_W-1:0]  cycles;
    } col_state_t;

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
        logic [PHASE_W-1:0] code;
        case (ph)
            ST_ABSORB: code = CODE_ABSORB;
            ST_PUMP:   code = CODE_PUMP;
            ST_SEAL:   code = CODE_SEAL;
            ST_DESORB: code = CODE_DESORB;
            ST_COOL:   code = CODE_COOL;
            default:   code = CODE_INIT;
        endcase
        return code;
    endfunction

endpackage

### sv/acsq_cfg.sv
// Configuration register file of the column sequencer.
// Depends on acsq_pkg.
module acsq_cfg
    import acsq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MIN_COOL_TIME: cfg_next.min_cool_time = cfg_wr_data[TIME_W-1:0];
                REG_MAX_COOL_TIME: cfg_next.max_cool_time = cfg_wr_data[TIME_W-1:0];
                REG_MIN_HEAT_TIME: cfg_next.min_heat_time = cfg_wr_data[TIME_W-1:0];
                REG_MAX_HEAT_TIME: cfg_next.max_heat_time = cfg_wr_data[TIME_W-1:0];
                REG_DESORB_TEMP:   cfg_next.desorb_temp   = $signed(cfg_wr_data[TEMP_W-1:0]);
                REG_ABSORB_TEMP:   cfg_next.absorb_temp   = $signed(cfg_wr_data[TEMP_W-1:0]);
                REG_VENT_PRESSURE: cfg_next.vent_pressure = cfg_wr_data[PRES_W-1:0];
                REG_FEED_PRESSURE: cfg_next.feed_pressure = cfg_wr_data[PRES_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_cool_time <= '0;
            cfg_reg.max_cool_time <= '1;
            cfg_reg.min_heat_time <= '0;
            cfg_reg.max_heat_time <= '1;
            cfg_reg.desorb_temp   <= '0;
            cfg_reg.absorb_temp   <= '0;
            cfg_reg.vent_pressure <= '0;
            cfg_reg.feed_pressure <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/acsq_front.sv
// Front end: takes a reading, range-checks the column and does the
// time compares against the registers. Depends on acsq_pkg.
module acsq_front
    import acsq_pkg::*;
#(
    parameter int NUM_COLUMNS = 4
)
(
    input  logic                     in_valid,
    input  logic        [IDX_W-1:0]  column_index,
    input  logic signed [TEMP_W-1:0] temperature,
    input  logic        [PRES_W-1:0] pressure,
    input  logic        [TIME_W-1:0] phase_time,
    input  cfg_t                     cfg,
    input  logic                     q_full,
    output logic                     in_stall,
    output logic                     q_push,
    output item_t                    q_item
);

    logic [31:0] idx_ext;

    assign idx_ext = {{(32-IDX_W){1'b0}}, column_index};

    always_comb
    begin
        q_item.column_index = column_index;
        q_item.in_range     = idx_ext < 32'(NUM_COLUMNS);
        q_item.temperature  = temperature;
        q_item.pressure     = pressure;
        q_item.cool_min_ok  = phase_time >= cfg.min_cool_time;
        q_item.cool_max_hit = phase_time >= cfg.max_cool_time;
        q_item.heat_min_ok  = phase_time >= cfg.min_heat_time;
        q_item.heat_max_hit = phase_time >= cfg.max_heat_time;
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

endmodule

### sv/acsq_queue.sv
// Short request queue between front and back end.
// Depends on acsq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module acsq_queue
    import acsq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t pop_item,
    output logic  empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = count_reg == DEPTH_CNT;
    assign empty    = count_reg == '0;
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    `ACSQ_ASSERT_IMP(a_q_no_overflow, clk, rst_n, full, !push)
    `ACSQ_ASSERT_IMP(a_q_ptrs_meet, clk, rst_n, empty || full, wr_ptr_reg == rd_ptr_reg)

endmodule

### sv/acsq_back.sv
// Back end: per-column phase state, the step of one column and the
// result register. Depends on acsq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module acsq_back
    import acsq_pkg::*;
#(
    parameter int NUM_COLUMNS    = 4,
    parameter int HEAT_MARGIN    = 20,
    parameter int AMBIENT_OUTLET = 1450
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     q_empty,
    input  item_t                    q_item,
    output logic                     q_pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic        [PHASE_W-1:0] phase,
    output logic signed [TEMP_W-1:0] temp_setpoint,
    output logic        [PRES_W-1:0] inlet_setpoint,
    output logic        [PRES_W-1:0] outlet_setpoint,
    output logic        [CYC_W-1:0]  cycle_count,
    output logic                     changed
);

    localparam int COL_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
    localparam logic signed [TEMP_W:0] MARGIN  = (TEMP_W + 1)'(HEAT_MARGIN);
    localparam logic        [PRES_W-1:0] AMBIENT = PRES_W'(AMBIENT_OUTLET);

    col_state_t col_reg [NUM_COLUMNS];

    logic [COL_W+IDX_W-1:0] col_wide;
    logic [COL_W-1:0]       col;
    col_state_t             cur;
    col_state_t             nxt;
    logic                   chg;
    logic signed [TEMP_W:0] temp_ext;
    logic signed [TEMP_W:0] tgt_ext;
    logic signed [TEMP_W:0] hot_lim;

    logic                     out_valid_reg;
    logic        [PHASE_W-1:0] phase_reg, phase_next;
    logic signed [TEMP_W-1:0] temp_reg, temp_next;
    logic        [PRES_W-1:0] inlet_reg, inlet_next;
    logic        [PRES_W-1:0] outlet_reg, outlet_next;
    logic        [CYC_W-1:0]  cycles_reg, cycles_next;
    logic                     changed_reg, changed_next;

    assign col_wide = {{COL_W{1'b0}}, q_item.column_index};
    assign col      = col_wide[COL_W-1:0];
    assign q_pop    = !q_empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        cur      = col_reg[col];
        nxt      = cur;
        chg      = 1'b0;
        temp_ext = {q_item.temperature[TEMP_W-1], q_item.temperature};
        tgt_ext  = {cur.temp[TEMP_W-1], cur.temp};
        hot_lim  = tgt_ext - MARGIN;
        case (cur.phase)
            ST_ABSORB:
            begin
                if ((temp_ext <= tgt_ext && q_item.cool_min_ok) || q_item.cool_max_hit)
                begin
                    nxt.phase  = ST_PUMP;
                    nxt.temp   = cfg.desorb_temp;
                    nxt.outlet = cfg.vent_pressure;
                    nxt.inlet  = '0;
                    chg        = 1'b1;
                end
            end
            ST_PUMP:
            begin
                if (q_item.pressure <= cur.outlet)
                begin
                    nxt.phase  = ST_SEAL;
                    nxt.temp   = cfg.desorb_temp;
                    nxt.outlet = cfg.vent_pressure;
                    nxt.inlet  = '0;
                    chg        = 1'b1;
                end
            end
            ST_SEAL:
            begin
                if (temp_ext >= hot_lim)
                begin
                    nxt.phase  = ST_DESORB;
                    nxt.temp   = cfg.desorb_temp;
                    nxt.outlet = cfg.vent_pressure;
                    nxt.inlet  = '0;
                    chg        = 1'b1;
                end
            end
            ST_DESORB:
            begin
                if ((temp_ext >= hot_lim && q_item.heat_min_ok) || q_item.heat_max_hit)
                begin
                    nxt.phase  = ST_COOL;
                    nxt.temp   = cfg.absorb_temp;
                    nxt.inlet  = cfg.feed_pressure;
                    nxt.outlet = AMBIENT;
                    chg        = 1'b1;
                end
            end
            ST_COOL:
            begin
                if ((temp_ext <= hot_lim && q_item.heat_min_ok) || q_item.heat_max_hit)
                begin
                    nxt.phase  = ST_ABSORB;
                    nxt.temp   = cfg.absorb_temp;
                    nxt.inlet  = cfg.feed_pressure;
                    nxt.outlet = AMBIENT;
                    nxt.cycles = cur.cycles + 1'b1;
                    chg        = 1'b1;
                end
            end
            default:
            begin
                // first entry to absorb: only the temperature target is loaded
                nxt.phase = ST_ABSORB;
                nxt.temp  = cfg.absorb_temp;
                chg       = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        temp_next    = temp_reg;
        inlet_next   = inlet_reg;
        outlet_next  = outlet_reg;
        cycles_next  = cycles_reg;
        changed_next = changed_reg;
        if (q_pop)
        begin
            if (q_item.in_range)
            begin
                phase_next   = phase_code(nxt.phase);
                temp_next    = nxt.temp;
                inlet_next   = nxt.inlet;
                outlet_next  = nxt.outlet;
                cycles_next  = nxt.cycles;
                changed_next = chg;
            end
            else
            begin
                phase_next   = CODE_INIT;
                temp_next    = '0;
                inlet_next   = '0;
                outlet_next  = '0;
                cycles_next  = '0;
                changed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COLUMNS; i++)
            begin
                col_reg[i].phase  <= ST_INIT;
                col_reg[i].temp   <= '0;
                col_reg[i].inlet  <= '0;
                col_reg[i].outlet <= '0;
                col_reg[i].cycles <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop && q_item.in_range)
            begin
                col_reg[col] <= nxt;
            end
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg   <= phase_next;
        temp_reg    <= temp_next;
        inlet_reg   <= inlet_next;
        outlet_reg  <= outlet_next;
        cycles_reg  <= cycles_next;
        changed_reg <= changed_next;
    end

    assign out_valid       = out_valid_reg;
    assign phase           = phase_reg;
    assign temp_setpoint   = temp_reg;
    assign inlet_setpoint  = inlet_reg;
    assign outlet_setpoint = outlet_reg;
    assign cycle_count     = cycles_reg;
    assign changed         = changed_reg;

    `ACSQ_ASSERT_IMP(a_no_pop_when_empty, clk, rst_n, q_empty, !q_pop)
    `ACSQ_ASSERT_IMP(a_no_pop_over_held, clk, rst_n, out_valid_reg && out_stall, !q_pop)
    `ACSQ_ASSERT_IMP(a_change_leaves_init, clk, rst_n, out_valid_reg && changed_reg,
                     phase_reg != CODE_INIT)

endmodule

### sv/adsorption_column_cycle_sequencer.sv
// Top level of the adsorption column cycle sequencer.
// Depends on acsq_pkg, acsq_cfg, acsq_front, acsq_queue and acsq_back.
//
// Each reading names a column and carries its temperature, pressure and
// time in phase; the column is stepped at most one phase along absorb,
// pump-down, seal, desorb and cool, and one result with the new phase,
// setpoints, cycle count and changed flag comes back per reading, in order.
// The block takes one reading per clock while in_stall is low; a result is
// registered and appears on the cycle after the back end pops the reading
// from the queue. That rate is set by the back end's read-modify-write of
// the column state on each pop. A two-entry queue sits between the front
// end and the back end, so up to two readings are still taken in while the
// result side is stalled. Column indexes at or above NUM_COLUMNS give an
// all-zero result and change nothing. The user is to write the registers
// only while the block is idle; the block itself does not enforce this.
module adsorption_column_cycle_sequencer
    import acsq_pkg::*;
#(
    parameter int NUM_COLUMNS    = 4,
    parameter int HEAT_MARGIN    = 20,
    parameter int AMBIENT_OUTLET = 1450
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic        [CFG_IDX_W-1:0]  cfg_index,
    input  logic        [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic        [IDX_W-1:0]   column_index,
    input  logic signed [TEMP_W-1:0]  temperature,
    input  logic        [PRES_W-1:0]  pressure,
    input  logic        [TIME_W-1:0]  phase_time,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic        [PHASE_W-1:0] phase,
    output logic signed [TEMP_W-1:0]  temp_setpoint,
    output logic        [PRES_W-1:0]  inlet_setpoint,
    output logic        [PRES_W-1:0]  outlet_setpoint,
    output logic        [CYC_W-1:0]   cycle_count,
    output logic                      changed
);

    cfg_t  cfg;
    item_t push_item;
    item_t pop_item;
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;

    acsq_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    acsq_front #(
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_front (
        .in_valid     (in_valid),
        .column_index (column_index),
        .temperature  (temperature),
        .pressure     (pressure),
        .phase_time   (phase_time),
        .cfg          (cfg),
        .q_full       (q_full),
        .in_stall     (in_stall),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    acsq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    acsq_back #(
        .NUM_COLUMNS    (NUM_COLUMNS),
        .HEAT_MARGIN    (HEAT_MARGIN),
        .AMBIENT_OUTLET (AMBIENT_OUTLET)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .q_empty         (q_empty),
        .q_item          (pop_item),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .phase           (phase),
        .temp_setpoint   (temp_setpoint),
        .inlet_setpoint  (inlet_setpoint),
        .outlet_setpoint (outlet_setpoint),
        .cycle_count     (cycle_count),
        .changed         (changed)
    );

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for adsorption_column_cycle_sequencer: directed table, a
// fast full-cycle run on one column, then random readings under several register settings.
// Depends on acsq_pkg and the block's RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import acsq_pkg::*;

    localparam int NUM_COLUMNS    = 4;
    localparam int HEAT_MARGIN    = 20;
    localparam int AMBIENT_OUTLET = 1450;
    localparam int FAST_CYCLES    = 24;
    localparam int PHASE_ITEMS    = 230;
    localparam int PLAN_ROWS      = 20;

    typedef struct packed {
        logic [PHASE_W-1:0]       phase;
        logic signed [TEMP_W-1:0] temp;
        logic [PRES_W-1:0]        inlet;
        logic [PRES_W-1:0]        outlet;
        logic [CYC_W-1:0]         cycles;
        logic                     changed;
    } column_report_t;

    typedef struct packed {
        logic [IDX_W-1:0]         col;
        logic signed [TEMP_W-1:0] temp;
        logic [PRES_W-1:0]        pres;
        logic [TIME_W-1:0]        dwell;
        logic                     typed;
        column_report_t           want;
    } plan_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_wr_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [IDX_W-1:0]          column_index;
    logic signed [TEMP_W-1:0]  temperature;
    logic [PRES_W-1:0]         pressure;
    logic [TIME_W-1:0]         phase_time;
    logic                      out_valid;
    logic                      out_stall;
    logic [PHASE_W-1:0]        phase;
    logic signed [TEMP_W-1:0]  temp_setpoint;
    logic [PRES_W-1:0]         inlet_setpoint;
    logic [PRES_W-1:0]         outlet_setpoint;
    logic [CYC_W-1:0]          cycle_count;
    logic                      changed;

    // Own copy of the registers and the per-column state
    cfg_t                      regs;
    logic [PHASE_W-1:0]        col_phase  [NUM_COLUMNS];
    logic signed [TEMP_W-1:0]  col_temp   [NUM_COLUMNS];
    logic [PRES_W-1:0]         col_inlet  [NUM_COLUMNS];
    logic [PRES_W-1:0]         col_outlet [NUM_COLUMNS];
    logic [CYC_W-1:0]          col_cycles [NUM_COLUMNS];

    column_report_t            awaited_reports [$];
    plan_row_t                 directed_plan [PLAN_ROWS];
    int                        fail_count = 0;
    bit                        gaps_on  = 1'b1;
    bit                        stall_on = 1'b1;
    bit                        valid_drv = 1'b0;
    int                        burst_left = 1;
    int                        stall_run = 0;

    adsorption_column_cycle_sequencer #(
        .NUM_COLUMNS    (NUM_COLUMNS),
        .HEAT_MARGIN    (HEAT_MARGIN),
        .AMBIENT_OUTLET (AMBIENT_OUTLET)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .column_index    (column_index),
        .temperature     (temperature),
        .pressure        (pressure),
        .phase_time      (phase_time),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .phase           (phase),
        .temp_setpoint   (temp_setpoint),
        .inlet_setpoint  (inlet_setpoint),
        .outlet_setpoint (outlet_setpoint),
        .cycle_count     (cycle_count),
        .changed         (changed)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void load_hot(input int c);
        col_temp[c]   = regs.desorb_temp;
        col_outlet[c] = regs.vent_pressure;
        col_inlet[c]  = '0;
    endfunction

    function automatic void load_cold(input int c);
        col_temp[c]   = regs.absorb_temp;
        col_inlet[c]  = regs.feed_pressure;
        col_outlet[c] = PRES_W'(AMBIENT_OUTLET);
    endfunction

    // Steps one column on a reading and returns the report the block should give
    function automatic column_report_t advance_column(
        input logic [IDX_W-1:0]         c,
        input logic signed [TEMP_W-1:0] t_meas,
        input logic [PRES_W-1:0]        p_meas,
        input logic [TIME_W-1:0]        dwell
    );
        column_report_t     r;
        int                 hot_edge;
        int                 tm;
        logic [PHASE_W-1:0] ph;
        logic               moved;
        r = '0;
        if (int'(c) >= NUM_COLUMNS)
            return r;
        ph       = col_phase[c];
        tm       = int'(t_meas);
        hot_edge = int'(col_temp[c]) - HEAT_MARGIN;
        moved    = 1'b0;
        case (ph)
            CODE_ABSORB:
                if ((tm <= int'(col_temp[c]) && dwell >= regs.min_cool_time)
                        || dwell >= regs.max_cool_time)
                begin
                    ph = CODE_PUMP;
                    load_hot(c);
                    moved = 1'b1;
                end
            CODE_PUMP:
                if (p_meas <= col_outlet[c])
                begin
                    ph = CODE_SEAL;
                    load_hot(c);
                    moved = 1'b1;
                end
            CODE_SEAL:
                if (tm >= hot_edge)
                begin
                    ph = CODE_DESORB;
                    load_hot(c);
                    moved = 1'b1;
                end
            CODE_DESORB:
                if ((tm >= hot_edge && dwell >= regs.min_heat_time)
                        || dwell >= regs.max_heat_time)
                begin
                    ph = CODE_COOL;
                    load_cold(c);
                    moved = 1'b1;
                end
            CODE_COOL:
                if ((tm <= hot_edge && dwell >= regs.min_heat_time)
                        || dwell >= regs.max_heat_time)
                begin
                    ph = CODE_ABSORB;
                    load_cold(c);
                    col_cycles[c] = col_cycles[c] + 1'b1;
                    moved = 1'b1;
                end
            default:
            begin
                // init (and any stray code): only the absorb temperature is taken
                ph = CODE_ABSORB;
                col_temp[c] = regs.absorb_temp;
                moved = 1'b1;
            end
        endcase
        col_phase[c] = ph;
        r.phase   = ph;
        r.temp    = col_temp[c];
        r.inlet   = col_inlet[c];
        r.outlet  = col_outlet[c];
        r.cycles  = col_cycles[c];
        r.changed = moved;
        return r;
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        c.min_cool_time = TIME_W'($urandom_range(0, 300));
        c.max_cool_time = ($urandom_range(0, 3) == 0) ? {TIME_W{1'b1}}
                                                      : TIME_W'($urandom_range(0, 1500));
        c.min_heat_time = TIME_W'($urandom_range(0, 300));
        c.max_heat_time = ($urandom_range(0, 3) == 0) ? {TIME_W{1'b1}}
                                                      : TIME_W'($urandom_range(0, 1500));
        c.desorb_temp   = TEMP_W'(int'($urandom_range(0, 4000)) - 1000);
        c.absorb_temp   = TEMP_W'(int'($urandom_range(0, 4000)) - 1000);
        c.vent_pressure = PRES_W'($urandom_range(0, 10000));
        c.feed_pressure = PRES_W'($urandom_range(0, 10000));
        return c;
    endfunction

    // Called at a rising edge with the block idle
    task automatic apply_config(input cfg_t c);
        logic [CFG_IDX_W-1:0]  idx [8];
        logic [CFG_DATA_W-1:0] val [8];
        idx = '{REG_MIN_COOL_TIME, REG_MAX_COOL_TIME, REG_MIN_HEAT_TIME, REG_MAX_HEAT_TIME,
                REG_DESORB_TEMP, REG_ABSORB_TEMP, REG_VENT_PRESSURE, REG_FEED_PRESSURE};
        val = '{CFG_DATA_W'(c.min_cool_time), CFG_DATA_W'(c.max_cool_time),
                CFG_DATA_W'(c.min_heat_time), CFG_DATA_W'(c.max_heat_time),
                CFG_DATA_W'($unsigned(c.desorb_temp)), CFG_DATA_W'($unsigned(c.absorb_temp)),
                CFG_DATA_W'(c.vent_pressure), CFG_DATA_W'(c.feed_pressure)};
        for (int i = 0; i < 8; i++)
        begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= idx[i];
            cfg_wr_data <= val[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        regs = c;
    endtask

    task automatic wait_idle();
        if (valid_drv)
        begin
            in_valid <= 1'b0;
            valid_drv = 1'b0;
        end
        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Offers one request, predicts on acceptance, then maybe leaves a gap
    task automatic send_reading(
        input logic [IDX_W-1:0]         c,
        input logic signed [TEMP_W-1:0] t_meas,
        input logic [PRES_W-1:0]        p_meas,
        input logic [TIME_W-1:0]        dwell,
        input logic                     typed,
        input column_report_t           typed_report
    );
        column_report_t predicted;
        int             gap;
        in_valid     <= 1'b1;
        valid_drv     = 1'b1;
        column_index <= c;
        temperature  <= t_meas;
        pressure     <= p_meas;
        phase_time   <= dwell;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = advance_column(c, t_meas, p_meas, dwell);
        awaited_reports.push_back(typed ? typed_report : predicted);
        if (gaps_on)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                gap = $urandom_range(1, 9);
                in_valid <= 1'b0;
                valid_drv = 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    // Readings mostly sit near the column's current exit thresholds
    task automatic pick_reading(
        output logic [IDX_W-1:0]         c,
        output logic signed [TEMP_W-1:0] t_meas,
        output logic [PRES_W-1:0]        p_meas,
        output logic [TIME_W-1:0]        dwell
    );
        int tv;
        int pv;
        int dv;
        int anchor;
        c = IDX_W'($urandom_range(0, NUM_COLUMNS - 1));
        if ($urandom_range(0, 3) == 0)
            tv = int'($urandom_range(0, 4000)) - 1000;
        else
            tv = int'(col_temp[c]) - 25 + int'($urandom_range(0, 30));
        if ($urandom_range(0, 3) == 0)
            pv = int'($urandom_range(0, 10000));
        else
            pv = int'(col_outlet[c]) - 3 + int'($urandom_range(0, 6));
        case ($urandom_range(0, 5))
            0:       anchor = int'(regs.min_cool_time);
            1:       anchor = int'(regs.max_cool_time);
            2:       anchor = int'(regs.min_heat_time);
            3:       anchor = int'(regs.max_heat_time);
            4:       anchor = int'($urandom_range(0, 2000));
            default: anchor = int'($urandom & 32'hFF_FFFF);
        endcase
        dv = anchor - 2 + int'($urandom_range(0, 4));
        t_meas = TEMP_W'(clamp(tv, -1000, 3000));
        p_meas = PRES_W'(clamp(pv, 0, 10000));
        dwell  = TIME_W'(clamp(dv, 0, 32'hFF_FFFF));
    endtask

    // Result side stalls in runs of its own
    always @(posedge clk)
    begin
        if (!rst_n || !stall_on)
            out_stall <= 1'b0;
        else if (stall_run <= 0)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                stall_run = $urandom_range(1, 6);
            end
            else
            begin
                out_stall <= 1'b0;
                stall_run = $urandom_range(1, 12);
            end
        end
        else
            stall_run--;
    end

    always @(posedge clk)
    begin : check_reports
        column_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_reports.size() == 0)
            begin
                $error("report with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = awaited_reports.pop_front();
                if (phase !== want.phase)
                begin
                    $error("phase: expected %0d, got %0d", want.phase, phase);
                    fail_count++;
                end
                if (temp_setpoint !== want.temp)
                begin
                    $error("temp_setpoint: expected %0d, got %0d", want.temp, temp_setpoint);
                    fail_count++;
                end
                if (inlet_setpoint !== want.inlet)
                begin
                    $error("inlet_setpoint: expected %0d, got %0d", want.inlet, inlet_setpoint);
                    fail_count++;
                end
                if (outlet_setpoint !== want.outlet)
                begin
                    $error("outlet_setpoint: expected %0d, got %0d",
                           want.outlet, outlet_setpoint);
                    fail_count++;
                end
                if (cycle_count !== want.cycles)
                begin
                    $error("cycle_count: expected %0d, got %0d", want.cycles, cycle_count);
                    fail_count++;
                end
                if (changed !== want.changed)
                begin
                    $error("changed: expected %0d, got %0d", want.changed, changed);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #30ms;
        $display("[adsorption_column_cycle_sequencer] ERROR");
        $finish;
    end

    initial
    begin
        logic [IDX_W-1:0]         c;
        logic signed [TEMP_W-1:0] t_meas;
        logic [PRES_W-1:0]        p_meas;
        logic [TIME_W-1:0]        dwell;
        cfg_t                     setting;

        rst_n        <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= '0;
        cfg_wr_data  <= '0;
        in_valid     <= 1'b0;
        column_index <= '0;
        temperature  <= '0;
        pressure     <= '0;
        phase_time   <= '0;

        regs = '{min_cool_time: '0, max_cool_time: '1, min_heat_time: '0,
                 max_heat_time: '1, desorb_temp: '0, absorb_temp: '0,
                 vent_pressure: '0, feed_pressure: '0};
        for (int i = 0; i < NUM_COLUMNS; i++)
        begin
            col_phase[i]  = CODE_INIT;
            col_temp[i]   = '0;
            col_inlet[i]  = '0;
            col_outlet[i] = '0;
            col_cycles[i] = '0;
        end

        // Reset register values: every target zero, max times at full scale
        directed_plan = '{
            '{2'd0,  3000, 10000, 24'd0,       1'b1, '{CODE_ABSORB, 0, 0, 0, 0, 1'b1}},
            '{2'd1, -1000,     0, 24'hFFFFFF,  1'b1, '{CODE_ABSORB, 0, 0, 0, 0, 1'b1}},
            '{2'd2,     0,  5000, 24'd1,       1'b1, '{CODE_ABSORB, 0, 0, 0, 0, 1'b1}},
            '{2'd3,     1,  8192, 24'd2,       1'b1, '{CODE_ABSORB, 0, 0, 0, 0, 1'b1}},
            '{2'd0,  3000,     0, 24'hFFFFFE,  1'b1, '{CODE_ABSORB, 0, 0, 0, 0, 1'b0}},
            '{2'd0,  3000,     0, 24'hFFFFFF,  1'b1, '{CODE_PUMP,   0, 0, 0, 0, 1'b1}},
            '{2'd0,     0, 10000, 24'd0,       1'b0, '0},
            '{2'd0,     0,     0, 24'd0,       1'b0, '0},
            '{2'd0, -1000,     0, 24'd0,       1'b0, '0},
            '{2'd0,   -20,     0, 24'd0,       1'b0, '0},
            '{2'd0,   -21,     0, 24'd0,       1'b0, '0},
            '{2'd0,   -20,     0, 24'd0,       1'b0, '0},
            '{2'd0,   -19,     0, 24'd5,       1'b0, '0},
            '{2'd0,   -20,     0, 24'd0,       1'b0, '0},
            '{2'd1,     0,     0, 24'd0,       1'b0, '0},
            '{2'd1,     0,     0, 24'd0,       1'b0, '0},
            '{2'd1,  3000,     0, 24'd0,       1'b0, '0},
            '{2'd1, -1000,     0, 24'hFFFFFF,  1'b0, '0},
            '{2'd1,  3000,     0, 24'hFFFFFF,  1'b0, '0},
            '{2'd2,     1,   100, 24'd100,     1'b0, '0}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_ROWS; i++)
            send_reading(directed_plan[i].col, directed_plan[i].temp, directed_plan[i].pres,
                         directed_plan[i].dwell, directed_plan[i].typed,
                         directed_plan[i].want);
        wait_idle();

        // Every phase exits at once: run column 0 round a number of full cycles
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        apply_config('{min_cool_time: '0, max_cool_time: '0, min_heat_time: '0,
                       max_heat_time: '0, desorb_temp: 3000, absorb_temp: -1000,
                       vent_pressure: 10000, feed_pressure: 10000});
        for (int n = 0; n < FAST_CYCLES * 5; n++)
            send_reading('0, TEMP_W'(2980 + int'($urandom_range(0, 20))),
                         PRES_W'($urandom_range(0, 10000)), TIME_W'($urandom), 1'b0, '0);
        wait_idle();

        for (int p = 0; p < 6; p++)
        begin
            if (p == 0)
                setting = '{min_cool_time: '1, max_cool_time: '1, min_heat_time: '1,
                            max_heat_time: '1, desorb_temp: -1000, absorb_temp: 3000,
                            vent_pressure: 0, feed_pressure: 10000};
            else if (p == 5)
                setting = '{min_cool_time: '0, max_cool_time: '0, min_heat_time: '0,
                            max_heat_time: '0, desorb_temp: -1000, absorb_temp: -1000,
                            vent_pressure: 0, feed_pressure: 0};
            else
                setting = random_config();
            gaps_on    = (p != 3);
            stall_on   = (p != 4);
            burst_left = $urandom_range(1, 24);
            apply_config(setting);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick_reading(c, t_meas, p_meas, dwell);
                send_reading(c, t_meas, p_meas, dwell, 1'b0, '0);
                // hold off mid-setting until the pipeline has emptied
                if (p == 2 && n == PHASE_ITEMS / 2)
                    wait_idle();
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("[adsorption_column_cycle_sequencer] OK");
        else
            $display("[adsorption_column_cycle_sequencer] ERROR");
        $finish;
    end

endmodule
